// ===== rtl/core/gcd_lcm_totient_unit_macros.svh =====
// ----------------------------------------------------------------------------
// gcd_lcm_totient_unit assertion macros
// Short forms for the clocked, reset-gated properties of the block.
// ----------------------------------------------------------------------------
`ifndef GCD_LCM_TOTIENT_UNIT_MACROS_SVH
`define GCD_LCM_TOTIENT_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define GLTU_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define GLTU_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/gltu_pkg.sv =====
// ----------------------------------------------------------------------------
// gltu_pkg
// Shared widths, operation codes, sequencer states and divider status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gltu_pkg;

    localparam int DATA_W = 32;
    localparam int MODE_W = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_GCD     = 2'd0,
        MODE_LCM     = 2'd1,
        MODE_COPRIME = 2'd2,
        MODE_TOTIENT = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_GCD_CHK,
        S_GCD_WAIT,
        S_LCM_WAIT,
        S_LCM_MUL,
        S_LCM_CHK,
        S_TOT_TEST,
        S_TOT_TEST_W,
        S_TOT_STRIP,
        S_TOT_STRIP_W,
        S_TOT_RED,
        S_TOT_RED_W,
        S_TOT_TAIL,
        S_TOT_TAIL_W,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== rtl/core/gltu_req_if.sv =====
// ----------------------------------------------------------------------------
// gltu_req_if
// Request channel: operation code and two operands with valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface gltu_req_if;

    logic                        valid;
    logic                        ready;
    logic [gltu_pkg::MODE_W-1:0] mode;
    logic [gltu_pkg::DATA_W-1:0] operand_a;
    logic [gltu_pkg::DATA_W-1:0] operand_b;

    modport source (output valid, mode, operand_a, operand_b, input ready);
    modport sink   (input valid, mode, operand_a, operand_b, output ready);

endinterface

// ===== rtl/core/gltu_rsp_if.sv =====
// ----------------------------------------------------------------------------
// gltu_rsp_if
// Response channel: result value and lcm overflow flag with valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface gltu_rsp_if;

    logic                        valid;
    logic                        ready;
    logic [gltu_pkg::DATA_W-1:0] value;
    logic                        overflow;

    modport source (output valid, value, overflow, input ready);
    modport sink   (input valid, value, overflow, output ready);

endinterface

// ===== rtl/core/gcd_lcm_totient_unit.sv =====
// ----------------------------------------------------------------------------
// gcd_lcm_totient_unit
// GCD, LCM with saturation, coprime test and Euler totient on one divider.
// ----------------------------------------------------------------------------
// One request at a time: req.ready is high only while the sequencer is idle,
// and a finished result waits in the output register while the next request
// is taken. Operands are cut to L = min(WIDTH, 32) bits. All work runs on one
// restoring divider. GCD and coprime run one division per Euclid step (at
// most about 1.44*L steps); LCM adds one more division and a registered
// multiply. Totient does trial division up to sqrt(n), so its number of
// divisions grows roughly as sqrt(n) plus the number of prime factors.
// n <= 2 finishes without any division.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "gcd_lcm_totient_unit_macros.svh"

module gcd_lcm_totient_unit #(
    parameter int WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    gltu_req_if.sink    req,
    gltu_rsp_if.source  rsp
);

    localparam int LW = (WIDTH < gltu_pkg::DATA_W) ? WIDTH : gltu_pkg::DATA_W;
    localparam int PW = 2 * LW;

    gltu_pkg::state_t state_reg, state_next;
    gltu_pkg::mode_t  mode_reg, mode_next;

    logic [LW-1:0] a_reg, a_next;
    logic [LW-1:0] b_reg, b_next;
    logic [LW-1:0] x_reg, x_next;
    logic [LW-1:0] y_reg, y_next;
    logic [LW-1:0] m_reg, m_next;
    logic [LW-1:0] p_reg, p_next;
    logic [LW-1:0] res_reg, res_next;
    logic [PW-1:0] prod_reg, prod_next;
    logic          ovf_reg, ovf_next;

    logic                        out_valid_reg, out_valid_next;
    logic [gltu_pkg::DATA_W-1:0] out_value_reg, out_value_next;
    logic                        out_ovf_reg, out_ovf_next;

    logic                  div_start;
    logic [LW-1:0]         div_dividend;
    logic [LW-1:0]         div_divisor;
    gltu_pkg::div_stat_t   div_stat;
    logic [LW-1:0]         div_q;
    logic [LW-1:0]         div_r;

    gltu_div #(
        .W (LW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .stat      (div_stat),
        .quotient  (div_q),
        .remainder (div_r)
    );

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        m_next         = m_reg;
        p_next         = p_reg;
        res_next       = res_reg;
        prod_next      = prod_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_value_next = out_value_reg;
        out_ovf_next   = out_ovf_reg;
        div_start      = 1'b0;
        div_dividend   = x_reg;
        div_divisor    = y_reg;

        case (state_reg)
            gltu_pkg::S_IDLE:
            begin
                if (req.valid)
                begin
                    mode_next  = gltu_pkg::mode_t'(req.mode);
                    a_next     = req.operand_a[LW-1:0];
                    b_next     = req.operand_b[LW-1:0];
                    ovf_next   = 1'b0;
                    state_next = gltu_pkg::S_START;
                end
            end
            gltu_pkg::S_START:
            begin
                x_next   = a_reg;
                y_next   = b_reg;
                m_next   = a_reg;
                res_next = a_reg;
                p_next   = LW'(2);
                case (mode_reg)
                    gltu_pkg::MODE_TOTIENT:
                    begin
                        if (a_reg <= LW'(2))
                        begin
                            res_next   = LW'(1);
                            state_next = gltu_pkg::S_FINISH;
                        end
                        else
                        begin
                            state_next = gltu_pkg::S_TOT_TEST;
                        end
                    end
                    gltu_pkg::MODE_LCM:
                    begin
                        if (a_reg == '0 || b_reg == '0)
                        begin
                            res_next   = '0;
                            state_next = gltu_pkg::S_FINISH;
                        end
                        else
                        begin
                            state_next = gltu_pkg::S_GCD_CHK;
                        end
                    end
                    default:
                    begin
                        state_next = gltu_pkg::S_GCD_CHK;
                    end
                endcase
            end
            gltu_pkg::S_GCD_CHK:
            begin
                if (y_reg == '0)
                begin
                    // x holds the gcd here
                    case (mode_reg)
                        gltu_pkg::MODE_GCD:
                        begin
                            res_next   = x_reg;
                            state_next = gltu_pkg::S_FINISH;
                        end
                        gltu_pkg::MODE_COPRIME:
                        begin
                            res_next   = (x_reg == LW'(1)) ? LW'(1) : '0;
                            state_next = gltu_pkg::S_FINISH;
                        end
                        gltu_pkg::MODE_LCM:
                        begin
                            div_start    = 1'b1;
                            div_dividend = a_reg;
                            div_divisor  = x_reg;
                            state_next   = gltu_pkg::S_LCM_WAIT;
                        end
                        default:
                        begin
                            state_next = gltu_pkg::S_FINISH;
                        end
                    endcase
                end
                else
                begin
                    div_start    = 1'b1;
                    div_dividend = x_reg;
                    div_divisor  = y_reg;
                    state_next   = gltu_pkg::S_GCD_WAIT;
                end
            end
            gltu_pkg::S_GCD_WAIT:
            begin
                if (div_stat.done)
                begin
                    x_next     = y_reg;
                    y_next     = div_r;
                    state_next = gltu_pkg::S_GCD_CHK;
                end
            end
            gltu_pkg::S_LCM_WAIT:
            begin
                if (div_stat.done)
                begin
                    x_next     = div_q;
                    state_next = gltu_pkg::S_LCM_MUL;
                end
            end
            gltu_pkg::S_LCM_MUL:
            begin
                prod_next  = PW'(x_reg) * PW'(b_reg);
                state_next = gltu_pkg::S_LCM_CHK;
            end
            gltu_pkg::S_LCM_CHK:
            begin
                // saturate when the product spills past L bits
                if (prod_reg[PW-1:LW] != '0)
                begin
                    res_next = '1;
                    ovf_next = 1'b1;
                end
                else
                begin
                    res_next = prod_reg[LW-1:0];
                end
                state_next = gltu_pkg::S_FINISH;
            end
            gltu_pkg::S_TOT_TEST:
            begin
                div_start    = 1'b1;
                div_dividend = m_reg;
                div_divisor  = p_reg;
                state_next   = gltu_pkg::S_TOT_TEST_W;
            end
            gltu_pkg::S_TOT_TEST_W:
            begin
                if (div_stat.done)
                begin
                    // m/p < p is the same as p*p > m: trial division is over
                    if (div_q < p_reg)
                    begin
                        state_next = gltu_pkg::S_TOT_TAIL;
                    end
                    else if (div_r == '0)
                    begin
                        m_next     = div_q;
                        state_next = gltu_pkg::S_TOT_STRIP;
                    end
                    else
                    begin
                        p_next     = p_reg + LW'(1);
                        state_next = gltu_pkg::S_TOT_TEST;
                    end
                end
            end
            gltu_pkg::S_TOT_STRIP:
            begin
                div_start    = 1'b1;
                div_dividend = m_reg;
                div_divisor  = p_reg;
                state_next   = gltu_pkg::S_TOT_STRIP_W;
            end
            gltu_pkg::S_TOT_STRIP_W:
            begin
                if (div_stat.done)
                begin
                    if (div_r == '0)
                    begin
                        m_next     = div_q;
                        state_next = gltu_pkg::S_TOT_STRIP;
                    end
                    else
                    begin
                        state_next = gltu_pkg::S_TOT_RED;
                    end
                end
            end
            gltu_pkg::S_TOT_RED:
            begin
                div_start    = 1'b1;
                div_dividend = res_reg;
                div_divisor  = p_reg;
                state_next   = gltu_pkg::S_TOT_RED_W;
            end
            gltu_pkg::S_TOT_RED_W:
            begin
                if (div_stat.done)
                begin
                    res_next   = res_reg - div_q;
                    p_next     = p_reg + LW'(1);
                    state_next = gltu_pkg::S_TOT_TEST;
                end
            end
            gltu_pkg::S_TOT_TAIL:
            begin
                // a leftover m above one is a prime factor of its own
                if (m_reg > LW'(1))
                begin
                    div_start    = 1'b1;
                    div_dividend = res_reg;
                    div_divisor  = m_reg;
                    state_next   = gltu_pkg::S_TOT_TAIL_W;
                end
                else
                begin
                    state_next = gltu_pkg::S_FINISH;
                end
            end
            gltu_pkg::S_TOT_TAIL_W:
            begin
                if (div_stat.done)
                begin
                    res_next   = res_reg - div_q;
                    state_next = gltu_pkg::S_FINISH;
                end
            end
            gltu_pkg::S_FINISH:
            begin
                // hold until the output register is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = gltu_pkg::DATA_W'(res_reg);
                    out_ovf_next   = ovf_reg;
                    state_next     = gltu_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = gltu_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gltu_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg      <= mode_next;
        a_reg         <= a_next;
        b_reg         <= b_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
        m_reg         <= m_next;
        p_reg         <= p_next;
        res_reg       <= res_next;
        prod_reg      <= prod_next;
        ovf_reg       <= ovf_next;
        out_value_reg <= out_value_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign req.ready    = (state_reg == gltu_pkg::S_IDLE);
    assign rsp.valid    = out_valid_reg;
    assign rsp.value    = out_value_reg;
    assign rsp.overflow = out_ovf_reg;

    `GLTU_ASSERT_IMP(a_div_start_idle, div_start, !div_stat.busy,
        "divider started while busy")
    `GLTU_ASSERT_IMP(a_div_done_waiting, div_stat.done,
        state_reg == gltu_pkg::S_GCD_WAIT || state_reg == gltu_pkg::S_LCM_WAIT ||
        state_reg == gltu_pkg::S_TOT_TEST_W || state_reg == gltu_pkg::S_TOT_STRIP_W ||
        state_reg == gltu_pkg::S_TOT_RED_W || state_reg == gltu_pkg::S_TOT_TAIL_W,
        "divider result with no wait state to take it")
    `GLTU_ASSERT_IMP(a_ovf_saturates, rsp.valid && rsp.overflow,
        rsp.value == gltu_pkg::DATA_W'({LW{1'b1}}),
        "overflow set without saturated value")
    `GLTU_ASSERT_NXT(a_accept_busy, req.valid && req.ready,
        state_reg == gltu_pkg::S_START,
        "accepted request did not start the sequencer")

endmodule

// ===== rtl/core/gltu_div.sv =====
// ----------------------------------------------------------------------------
// gltu_div
// Restoring unsigned divider, one quotient bit per cycle. Results hold
// until the next start; done pulses for one cycle when they are ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gltu_div #(
    parameter int W = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [W-1:0]          dividend,
    input  logic [W-1:0]          divisor,
    output gltu_pkg::div_stat_t   stat,
    output logic [W-1:0]          quotient,
    output logic [W-1:0]          remainder
);

    localparam int CW = (W > 1) ? $clog2(W) : 1;

    logic [W-1:0]  q_reg, q_next;
    logic [W-1:0]  r_reg, r_next;
    logic [W-1:0]  d_reg, d_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    trial;

    // Shift the next dividend bit into the partial remainder and try the subtract.
    assign trial = {r_reg, q_reg[W-1]} - {1'b0, d_reg};

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[W])
            begin
                r_next = trial[W-1:0];
                q_next = {q_reg[W-2:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[W-2:0], q_reg[W-1]};
                q_next = {q_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for gcd_lcm_totient_unit. A queue of requests feeds a
// clocked driver, and a clocked monitor checks every response in order against
// a local number-theory predictor. The run starts with directed corner cases
// and then moves on to random gcd, lcm, coprime and totient requests. Both
// channels see random idle cycles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    import gltu_pkg::*;

    localparam int          TB_WIDTH     = 32;
    localparam int          EFF_W        = (TB_WIDTH < 32) ? TB_WIDTH : 32;
    localparam int          RANDOM_OPS   = 1750;
    localparam int          DRAIN_AT     = 900;
    localparam int          TAIL_CYCLES  = 100;
    localparam longint      LIMIT_CYCLES = 40_000_000;
    localparam logic [31:0] ALL_ONES     = 32'hFFFF_FFFF;

    typedef struct {
        mode_t       mode;
        logic [31:0] a;
        logic [31:0] b;
        bit          drain;
    } math_op_t;

    typedef struct {
        math_op_t    op;
        logic [31:0] value;
        logic        overflow;
    } math_answer_t;

    logic clk;
    logic rst_n;

    gltu_req_if req_ch ();
    gltu_rsp_if rsp_ch ();

    gcd_lcm_totient_unit #(
        .WIDTH (TB_WIDTH)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    math_op_t     queued_ops[$];
    math_answer_t pending_answers[$];

    int unsigned  err_cnt;
    int unsigned  sent_cnt;
    int unsigned  got_cnt;
    int unsigned  send_gap;
    int unsigned  recv_gap;
    longint       cycle_cnt;

    function automatic longint unsigned euclid(longint unsigned x, longint unsigned y);
        longint unsigned t;
        while (y != 0)
        begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // Trial division over the shrinking cofactor.
    function automatic longint unsigned phi_of(longint unsigned n);
        longint unsigned acc;
        longint unsigned m;
        longint unsigned p;
        if (n <= 2)
            return 1;
        acc = n;
        m   = n;
        for (p = 2; p * p <= m; p++)
        begin
            if (m % p == 0)
            begin
                while (m % p == 0)
                    m = m / p;
                acc -= acc / p;
            end
        end
        if (m > 1)
            acc -= acc / m;
        return acc;
    endfunction

    function automatic math_answer_t number_theory_answer(math_op_t op);
        longint unsigned lim;
        longint unsigned a;
        longint unsigned b;
        longint unsigned v;
        longint unsigned g;
        math_answer_t    ans;
        lim          = (64'd1 << EFF_W) - 1;
        a            = op.a & lim;
        b            = op.b & lim;
        v            = 0;
        ans.op       = op;
        ans.overflow = 1'b0;
        case (op.mode)
            MODE_GCD:     v = euclid(a, b);
            MODE_LCM:
            begin
                if (a != 0 && b != 0)
                begin
                    g = euclid(a, b);
                    v = (a / g) * b;
                    if (v > lim)
                    begin
                        v            = lim;
                        ans.overflow = 1'b1;
                    end
                end
            end
            MODE_COPRIME: v = (euclid(a, b) == 1) ? 1 : 0;
            default:      v = phi_of(a);
        endcase
        ans.value = v[31:0];
        return ans;
    endfunction

    task automatic report(string what);
        $display("[%0t] MISMATCH %s", $time, what);
        err_cnt++;
    endtask

    task automatic queue_op(mode_t m, logic [31:0] a, logic [31:0] b, bit drain = 1'b0);
        math_op_t op;
        op.mode  = m;
        op.a     = a;
        op.b     = b;
        op.drain = drain;
        queued_ops.insert(queued_ops.size(), op);
    endtask

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return 32'd1;
            2:       return ALL_ONES;
            3:       return $urandom_range(0, 255);
            4, 5:    return $urandom_range(0, 65535);
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Request driver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid     <= 1'b0;
            req_ch.mode      <= MODE_GCD;
            req_ch.operand_a <= '0;
            req_ch.operand_b <= '0;
            send_gap         <= 0;
            sent_cnt         <= 0;
        end
        else
        begin : drive
            int unsigned gap_now;
            bit          calm;
            gap_now = send_gap;
            calm    = (sent_cnt % 500) >= 400;
            if (req_ch.valid && req_ch.ready)
            begin
                pending_answers.insert(pending_answers.size(),
                                       number_theory_answer(queued_ops[0]));
                queued_ops.pop_front();
                sent_cnt <= sent_cnt + 1;
                gap_now = calm ? 0 : pick_gap();
            end
            if (req_ch.valid && !req_ch.ready)
            begin
                // hold the request until taken
            end
            else if (gap_now != 0)
            begin
                gap_now--;
                req_ch.valid <= 1'b0;
            end
            else if (queued_ops.size() != 0 &&
                     (!queued_ops[0].drain || pending_answers.size() == 0))
            begin
                req_ch.valid     <= 1'b1;
                req_ch.mode      <= queued_ops[0].mode;
                req_ch.operand_a <= queued_ops[0].a;
                req_ch.operand_b <= queued_ops[0].b;
            end
            else
            begin
                req_ch.valid <= 1'b0;
            end
            send_gap <= gap_now;
        end
    end

    // Response monitor.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            recv_gap     <= 0;
            got_cnt      <= 0;
        end
        else
        begin : watch
            int unsigned  gap_now;
            bit           calm;
            math_answer_t want;
            gap_now = recv_gap;
            calm    = (got_cnt % 450) < 80;
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got_cnt <= got_cnt + 1;
                if (pending_answers.size() == 0)
                begin
                    report($sformatf("unexpected result value=0x%0h overflow=%0b",
                                     rsp_ch.value, rsp_ch.overflow));
                end
                else
                begin
                    want = pending_answers.pop_front();
                    if (rsp_ch.value !== want.value)
                        report($sformatf(
                            "value mode=%0d a=0x%0h b=0x%0h: got 0x%0h, exp 0x%0h",
                            want.op.mode, want.op.a, want.op.b,
                            rsp_ch.value, want.value));
                    if (rsp_ch.overflow !== want.overflow)
                        report($sformatf(
                            "overflow mode=%0d a=0x%0h b=0x%0h: got %0b, exp %0b",
                            want.op.mode, want.op.a, want.op.b,
                            rsp_ch.overflow, want.overflow));
                end
                gap_now = calm ? 0 : pick_gap();
            end
            else if (rsp_ch.ready && !calm && $urandom_range(0, 99) < 3)
            begin
                gap_now = pick_gap();
            end
            if (gap_now != 0)
            begin
                gap_now--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
            recv_gap <= gap_now;
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        int unsigned sel;
        int unsigned g;
        int unsigned kmax;
        logic [31:0] x;
        logic [31:0] y;
        mode_t       m;

        err_cnt   = 0;
        cycle_cnt = 0;
        rst_n    <= 1'b0;

        // gcd corners, including the longest Euclid chain in 32 bits
        queue_op(MODE_GCD, 32'd0, 32'd0);
        queue_op(MODE_GCD, 32'd12345, 32'd0);
        queue_op(MODE_GCD, 32'd0, ALL_ONES);
        queue_op(MODE_GCD, ALL_ONES, ALL_ONES);
        queue_op(MODE_GCD, ALL_ONES, 32'd1);
        queue_op(MODE_GCD, 32'd2971215073, 32'd1836311903);
        // lcm: zero operands, fit at the edge, saturation
        queue_op(MODE_LCM, 32'd0, 32'd0);
        queue_op(MODE_LCM, 32'd0, 32'd5);
        queue_op(MODE_LCM, 32'd7, 32'd0);
        queue_op(MODE_LCM, 32'd65536, 32'd65535);
        queue_op(MODE_LCM, 32'd65536, 32'd65537);
        queue_op(MODE_LCM, ALL_ONES, ALL_ONES - 1);
        queue_op(MODE_LCM, ALL_ONES, ALL_ONES);
        queue_op(MODE_LCM, ALL_ONES, 32'd1);
        // coprime: gcd of one with zero counts, zero with zero does not
        queue_op(MODE_COPRIME, 32'd0, 32'd1);
        queue_op(MODE_COPRIME, 32'd0, 32'd0);
        queue_op(MODE_COPRIME, 32'd6, 32'd9);
        queue_op(MODE_COPRIME, ALL_ONES, ALL_ONES - 1);
        // totient: small n, a prime, a composite, the all-ones word
        queue_op(MODE_TOTIENT, 32'd0, ALL_ONES);
        queue_op(MODE_TOTIENT, 32'd1, 32'd0);
        queue_op(MODE_TOTIENT, 32'd2, 32'd7);
        queue_op(MODE_TOTIENT, 32'd3, 32'd0);
        queue_op(MODE_TOTIENT, 32'd97, ALL_ONES);
        queue_op(MODE_TOTIENT, 32'd1000, 32'd3);
        queue_op(MODE_TOTIENT, ALL_ONES, 32'd0);

        for (int i = 0; i < RANDOM_OPS; i++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 30)
                m = MODE_GCD;
            else if (sel < 55)
                m = MODE_LCM;
            else if (sel < 80)
                m = MODE_COPRIME;
            else
                m = MODE_TOTIENT;

            if (m == MODE_TOTIENT)
            begin
                // keep n small: cost grows with sqrt(n)
                sel = $urandom_range(0, 99);
                if (sel < 70)
                    x = $urandom_range(0, 255);
                else if (sel < 95)
                    x = $urandom_range(256, 4095);
                else
                    x = $urandom_range(4096, 65535);
                y = $urandom;
            end
            else if ($urandom_range(0, 9) < 4)
            begin
                // share a factor so the gcd is not trivial
                g    = $urandom_range(1, 1000);
                kmax = $urandom_range(0, 1) ? ALL_ONES / g : 255;
                x    = g * $urandom_range(0, kmax);
                y    = g * $urandom_range(0, kmax);
            end
            else
            begin
                x = rand_operand();
                y = rand_operand();
            end
            queue_op(m, x, y, i == DRAIN_AT);
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (queued_ops.size() != 0 || pending_answers.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (pending_answers.size() != 0)
            report($sformatf("%0d results never arrived", pending_answers.size()));

        if (err_cnt == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
